@@ sv/cwu_pkg.sv @@
// ----------------------------------------------------------------------------
// cwu_pkg
// Shared types and constants for the Reno congestion window unit.
// ----------------------------------------------------------------------------
`default_nettype none

package cwu_pkg;

  localparam int WIN_W = 16;
  localparam int SEQ_W = 32;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [WIN_W-1:0] WIN_MAX = {WIN_W{1'b1}};
  localparam logic [WIN_W-1:0] THRESH_RESET = WIN_W'(32);
  localparam logic [WIN_W-1:0] LIMIT_RESET = WIN_W'(20);
  localparam logic [WIN_W-1:0] FAST_ADD = WIN_W'(3);
  localparam logic [1:0] DUP_LIMIT = 2'd3;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    OP_ACK         = 2'd0,
    OP_TIMEOUT     = 2'd1,
    OP_RESEND_DONE = 2'd2,
    OP_RESTART     = 2'd3
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_START_ACK   = 2'd0,
    CFG_LAST_PACKET = 2'd1,
    CFG_WIN_LIMIT   = 2'd2
  } cfg_idx_t;

  typedef enum logic [2:0] {
    KIND_NOP         = 3'd0,
    KIND_ACK         = 3'd1,
    KIND_TIMEOUT     = 3'd2,
    KIND_RESEND_DONE = 3'd3,
    KIND_RESTART     = 3'd4
  } kind_t;

  typedef struct packed {
    kind_t             kind;
    logic              is_last;
    logic [SEQ_W-1:0]  ack_number;
    logic [SEQ_W-1:0]  packet_index;
  } cmd_t;

  typedef struct packed {
    logic [SEQ_W-1:0]  window_base;
    logic [WIN_W-1:0]  cong_window;
    logic [WIN_W-1:0]  slow_threshold;
    logic              in_slow_start;
    logic [WIN_W-1:0]  send_window;
    logic              resend_request;
    logic              transfer_done;
  } result_t;

endpackage

`default_nettype wire

@@ sv/cwu_front.sv @@
// ----------------------------------------------------------------------------
// cwu_front
// Input stage: accepts events, decodes them into commands for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module cwu_front (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic [1:0]                in_operation,
  input  wire logic                      in_ack_valid,
  input  wire logic [cwu_pkg::SEQ_W-1:0] in_ack_number,
  input  wire logic [cwu_pkg::SEQ_W-1:0] in_packet_index,
  input  wire logic                      in_valid,
  output      logic                      in_ready,
  input  wire logic [cwu_pkg::SEQ_W-1:0] last_packet_index,
  output      logic                      cmd_valid,
  output      cwu_pkg::cmd_t             cmd,
  input  wire logic                      cmd_ready
);
  import cwu_pkg::*;

  logic  valid_r;
  cmd_t  cmd_r;
  cmd_t  cmd_nxt;
  logic  accept;

  always_comb begin
    cmd_nxt.ack_number   = in_ack_number;
    cmd_nxt.packet_index = in_packet_index;
    cmd_nxt.is_last      = (in_packet_index == last_packet_index);
    unique case (op_t'(in_operation))
      OP_ACK:         cmd_nxt.kind = in_ack_valid ? KIND_ACK : KIND_NOP;
      OP_TIMEOUT:     cmd_nxt.kind = KIND_TIMEOUT;
      OP_RESEND_DONE: cmd_nxt.kind = KIND_RESEND_DONE;
      OP_RESTART:     cmd_nxt.kind = KIND_RESTART;
      default:        cmd_nxt.kind = KIND_NOP;
    endcase
  end

  assign in_ready  = !valid_r || cmd_ready;
  assign accept    = in_valid && in_ready;
  assign cmd_valid = valid_r;
  assign cmd       = cmd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (accept) begin
      valid_r <= 1'b1;
    end else if (cmd_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r <= cmd_nxt;
    end
  end

endmodule

`default_nettype wire

@@ sv/cwu_queue.sv @@
// ----------------------------------------------------------------------------
// cwu_queue
// Short command queue between the front and back ends.
// ----------------------------------------------------------------------------
`default_nettype none

module cwu_queue (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push_valid,
  input  wire cwu_pkg::cmd_t push_data,
  output      logic          push_ready,
  output      logic          pop_valid,
  output      cwu_pkg::cmd_t pop_data,
  input  wire logic          pop_ready
);
  import cwu_pkg::*;

  cmd_t               data_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr_r;
  logic [QPTR_W-1:0]  rd_ptr_r;
  logic [QCNT_W-1:0]  count_r;
  logic               push;
  logic               pop;

  assign push_ready = (count_r != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = data_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + QCNT_W'(1);
      end else if (pop && !push) begin
        count_r <= count_r - QCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      data_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

@@ sv/cwu_back.sv @@
// ----------------------------------------------------------------------------
// cwu_back
// Congestion state and sliding window update, with the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module cwu_back (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      cmd_valid,
  input  wire cwu_pkg::cmd_t             cmd,
  output      logic                      cmd_ready,
  input  wire logic [cwu_pkg::SEQ_W-1:0] start_ack,
  input  wire logic [cwu_pkg::WIN_W-1:0] window_limit,
  output      logic                      res_valid,
  output      cwu_pkg::result_t          res,
  input  wire logic                      res_ready
);
  import cwu_pkg::*;

  logic [WIN_W-1:0] wc_r, wc_nxt;
  logic [WIN_W-1:0] th_r, th_nxt;
  logic             slow_r, slow_nxt;
  logic [WIN_W-1:0] ac_r, ac_nxt;
  logic [1:0]       dc_r, dc_nxt;
  logic [SEQ_W-1:0] latest_r, latest_nxt;
  logic [SEQ_W-1:0] base_r, base_nxt;
  logic             done_r, done_nxt;
  logic             resend_r, resend_nxt;
  logic             res_valid_r;
  result_t          res_r, res_nxt;

  logic             pop;
  logic [SEQ_W:0]   next_ack;
  logic [SEQ_W:0]   ack_wide;
  logic [WIN_W-1:0] wc_inc;
  logic [WIN_W-1:0] ac_inc;
  logic [1:0]       dc_inc;
  logic [WIN_W-1:0] lim;

  assign cmd_ready = !res_valid_r || res_ready;
  assign pop       = cmd_valid && cmd_ready;

  assign next_ack = {1'b0, latest_r} + (SEQ_W+1)'(1);
  assign ack_wide = {1'b0, cmd.ack_number};
  assign wc_inc   = (wc_r == WIN_MAX) ? wc_r : wc_r + WIN_W'(1);
  assign ac_inc   = (ac_r == WIN_MAX) ? ac_r : ac_r + WIN_W'(1);
  assign dc_inc   = dc_r + 2'd1;

  always_comb begin
    wc_nxt     = wc_r;
    th_nxt     = th_r;
    slow_nxt   = slow_r;
    ac_nxt     = ac_r;
    dc_nxt     = dc_r;
    latest_nxt = latest_r;
    base_nxt   = base_r;
    done_nxt   = done_r;
    resend_nxt = resend_r;
    case (cmd.kind)
      KIND_ACK: begin
        if (!done_r) begin
          if (ack_wide == next_ack) begin
            base_nxt   = base_r + SEQ_W'(1);
            latest_nxt = cmd.ack_number;
            dc_nxt     = 2'd0;
            if (cmd.is_last) begin
              done_nxt = 1'b1;
            end else if (slow_r) begin
              wc_nxt = wc_inc;
              if (wc_inc >= th_r) begin
                slow_nxt = 1'b0;
              end
            end else if (ac_inc >= wc_r) begin
              // A full window of acks in avoidance grows the window by one.
              wc_nxt = wc_inc;
              ac_nxt = '0;
            end else begin
              ac_nxt = ac_inc;
            end
          end else if (cmd.ack_number == latest_r) begin
            if (dc_inc == DUP_LIMIT) begin
              // Third duplicate: fast resend with a halved threshold.
              dc_nxt     = 2'd0;
              resend_nxt = 1'b1;
              th_nxt     = wc_r >> 1;
              wc_nxt     = (wc_r >> 1) + FAST_ADD;
              slow_nxt   = 1'b0;
              ac_nxt     = '0;
            end else begin
              dc_nxt = dc_inc;
            end
          end else if (ack_wide > next_ack) begin
            base_nxt   = cmd.packet_index + SEQ_W'(1);
            latest_nxt = cmd.ack_number;
            dc_nxt     = 2'd0;
          end
        end
      end
      KIND_TIMEOUT: begin
        if (!resend_r && !done_r) begin
          dc_nxt     = 2'd0;
          ac_nxt     = '0;
          resend_nxt = 1'b1;
          slow_nxt   = 1'b1;
          th_nxt     = wc_r >> 1;
          wc_nxt     = WIN_W'(1);
        end
      end
      KIND_RESEND_DONE: begin
        resend_nxt = 1'b0;
      end
      KIND_RESTART: begin
        latest_nxt = start_ack;
        base_nxt   = '0;
        done_nxt   = 1'b0;
        resend_nxt = 1'b0;
        dc_nxt     = 2'd0;
        ac_nxt     = '0;
      end
      default: begin
      end
    endcase
  end

  assign lim = (window_limit == '0) ? WIN_W'(1) : window_limit;

  always_comb begin
    res_nxt.window_base    = base_nxt;
    res_nxt.cong_window    = wc_nxt;
    res_nxt.slow_threshold = th_nxt;
    res_nxt.in_slow_start  = slow_nxt;
    res_nxt.send_window    = (lim < wc_nxt) ? lim : wc_nxt;
    res_nxt.resend_request = resend_nxt;
    res_nxt.transfer_done  = done_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wc_r        <= WIN_W'(1);
      th_r        <= THRESH_RESET;
      slow_r      <= 1'b1;
      ac_r        <= '0;
      dc_r        <= 2'd0;
      latest_r    <= '0;
      base_r      <= '0;
      done_r      <= 1'b0;
      resend_r    <= 1'b0;
      res_valid_r <= 1'b0;
    end else begin
      if (pop) begin
        wc_r     <= wc_nxt;
        th_r     <= th_nxt;
        slow_r   <= slow_nxt;
        ac_r     <= ac_nxt;
        dc_r     <= dc_nxt;
        latest_r <= latest_nxt;
        base_r   <= base_nxt;
        done_r   <= done_nxt;
        resend_r <= resend_nxt;
      end
      if (pop) begin
        res_valid_r <= 1'b1;
      end else if (res_ready) begin
        res_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      res_r <= res_nxt;
    end
  end

  assign res_valid = res_valid_r;
  assign res       = res_r;

endmodule

`default_nettype wire

@@ sv/reno_congestion_window_unit.sv @@
// ----------------------------------------------------------------------------
// reno_congestion_window_unit
// Sender-side Reno congestion window and sliding window tracker.
// ----------------------------------------------------------------------------
// One event (ack, retransmit timeout, resend finished, restart) is taken per
// cycle while the output is not stalled, and yields exactly one result
// showing the state after that event. An event passes a decode register, a
// two-entry command queue and the state update with its result register,
// from which the result is presented. Sustained throughput is one item per
// cycle while the output is not held; the queue lets the input keep flowing
// for two more items while the output is held. Configuration writes are
// taken at any time but should only be made while no item is in flight.
`default_nettype none

module reno_congestion_window_unit (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output      logic                           in_ready,
  input  wire logic [1:0]                     in_operation,
  input  wire logic                           in_ack_valid,
  input  wire logic [cwu_pkg::SEQ_W-1:0]      in_ack_number,
  input  wire logic [cwu_pkg::SEQ_W-1:0]      in_packet_index,
  output      logic                           out_valid,
  input  wire logic                           out_ready,
  output      logic [cwu_pkg::SEQ_W-1:0]      out_window_base,
  output      logic [cwu_pkg::WIN_W-1:0]      out_cong_window,
  output      logic [cwu_pkg::WIN_W-1:0]      out_slow_threshold,
  output      logic                           out_in_slow_start,
  output      logic [cwu_pkg::WIN_W-1:0]      out_send_window,
  output      logic                           out_resend_request,
  output      logic                           out_transfer_done,
  input  wire logic                           cfg_we,
  input  wire logic [cwu_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [cwu_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import cwu_pkg::*;

  logic [SEQ_W-1:0] start_ack_r;
  logic [SEQ_W-1:0] last_packet_r;
  logic [WIN_W-1:0] win_limit_r;

  logic    front_valid;
  cmd_t    front_cmd;
  logic    front_ready;
  logic    q_valid;
  cmd_t    q_cmd;
  logic    q_ready;
  result_t res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_ack_r   <= '0;
      last_packet_r <= '0;
      win_limit_r   <= LIMIT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_START_ACK:   start_ack_r   <= cfg_wdata[SEQ_W-1:0];
        CFG_LAST_PACKET: last_packet_r <= cfg_wdata[SEQ_W-1:0];
        CFG_WIN_LIMIT:   win_limit_r   <= cfg_wdata[WIN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  cwu_front u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_operation      (in_operation),
    .in_ack_valid      (in_ack_valid),
    .in_ack_number     (in_ack_number),
    .in_packet_index   (in_packet_index),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .last_packet_index (last_packet_r),
    .cmd_valid         (front_valid),
    .cmd               (front_cmd),
    .cmd_ready         (front_ready)
  );

  cwu_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (front_valid),
    .push_data  (front_cmd),
    .push_ready (front_ready),
    .pop_valid  (q_valid),
    .pop_data   (q_cmd),
    .pop_ready  (q_ready)
  );

  cwu_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd_valid    (q_valid),
    .cmd          (q_cmd),
    .cmd_ready    (q_ready),
    .start_ack    (start_ack_r),
    .window_limit (win_limit_r),
    .res_valid    (out_valid),
    .res          (res),
    .res_ready    (out_ready)
  );

  assign out_window_base    = res.window_base;
  assign out_cong_window    = res.cong_window;
  assign out_slow_threshold = res.slow_threshold;
  assign out_in_slow_start  = res.in_slow_start;
  assign out_send_window    = res.send_window;
  assign out_resend_request = res.resend_request;
  assign out_transfer_done  = res.transfer_done;

endmodule

`default_nettype wire

@@ sv/cwu_checker.sv @@
// ----------------------------------------------------------------------------
// cwu_checker
// Port-level checks for the Reno congestion window unit, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module cwu_checker (
  input wire logic                      clk,
  input wire logic                      rst_n,
  input wire logic                      out_valid,
  input wire logic                      out_ready,
  input wire logic [cwu_pkg::SEQ_W-1:0] out_window_base,
  input wire logic [cwu_pkg::WIN_W-1:0] out_cong_window,
  input wire logic [cwu_pkg::WIN_W-1:0] out_send_window
);

  // Nothing is presented in the cycle after a reset.
  a_reset_clears_out : assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // A stalled result holds its value.
  a_out_hold : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_window_base)
      && $stable(out_cong_window) && $stable(out_send_window))
    else $error("stalled result changed");

  // The congestion window never collapses to zero.
  a_cwnd_nonzero : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_cong_window != '0)
    else $error("congestion window is zero");

  // The send window is bounded by the congestion window and never zero.
  a_send_bounded : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_send_window <= out_cong_window && out_send_window != '0)
    else $error("send window out of range");

endmodule

bind reno_congestion_window_unit cwu_checker u_cwu_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_window_base (out_window_base),
  .out_cong_window (out_cong_window),
  .out_send_window (out_send_window)
);

`default_nettype wire
